// ===== design/time_sorted_event_table_defines.svh =====
// assertion helpers shared by the table logic
// both expect signals named clk and rst in the enclosing module
`ifndef TIME_SORTED_EVENT_TABLE_DEFINES_SVH
`define TIME_SORTED_EVENT_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TSET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tset_pkg.sv =====
`timescale 1ns / 1ps

package tset_pkg;

  // fixed field widths of the stream items
  localparam int STAMP_W    = 48;
  localparam int PAYLOAD_W  = 32;
  localparam int POS_W      = 4;
  localparam int FILL_W     = 5;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_READ,
    ST_DONE
  } state_t;

  // one incoming request
  typedef struct packed {
    cmd_t                 cmd;
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
    logic [POS_W-1:0]     position;
  } req_t;

  // one outgoing result
  typedef struct packed {
    logic                 found;
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
    logic                 dropped;
    logic [FILL_W-1:0]    fill;
  } res_t;

endpackage

// ===== design/tset_ram.sv =====
`timescale 1ns / 1ps

module tset_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/tset_seq.sv =====
`timescale 1ns / 1ps
`include "time_sorted_event_table_defines.svh"

module tset_seq
  import tset_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int AW          = $clog2(DEPTH),
  localparam int CW          = $clog2(DEPTH + 1),
  localparam int W           = STAMP_W + PAYLOAD_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          req,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [W-1:0]  rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [W-1:0]  wr_data
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           idx, idx_next;
  logic [AW-1:0]           sh, sh_next;
  logic [AW-1:0]           k, k_next;
  logic [W-1:0]            prev, prev_next;
  cmd_t                    cmd_q, cmd_next;
  logic [STAMP_W-1:0]      stamp_q, stamp_next;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_next;
  logic                    res_found, res_found_next;
  logic                    res_drop, res_drop_next;
  logic [W-1:0]            res_word, res_word_next;

  logic [STAMP_W-1:0]      cur_t;
  logic [STAMP_W-1:0]      prev_t;
  logic [STAMP_W-1:0]      d_pre;
  logic [STAMP_W-1:0]      d_next;
  logic                    at_last;
  logic                    full;
  logic                    pick_prev;
  logic [AW-1:0]           last_addr;

  // compare of the entry just read against the request time
  assign cur_t     = rd_data[STAMP_W-1:0];
  assign prev_t    = prev[STAMP_W-1:0];
  assign d_pre     = stamp_q - prev_t;
  assign d_next    = cur_t - stamp_q;
  assign last_addr = AW'(count - CW'(1));
  assign at_last   = (idx == last_addr);
  assign full      = (count == CW'(DEPTH));
  assign pick_prev = (idx != '0) && (d_pre < d_next);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // result as seen by the output register
  always_comb begin
    res.found   = res_found;
    res.stamp   = res_found ? res_word[STAMP_W-1:0] : '0;
    res.payload = res_found ? PAYLOAD_W'(res_word[W-1:STAMP_W]) : '0;
    res.dropped = res_drop;
    res.fill    = FILL_W'(count);
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx       <= idx_next;
    sh        <= sh_next;
    k         <= k_next;
    prev      <= prev_next;
    cmd_q     <= cmd_next;
    stamp_q   <= stamp_next;
    pay_q     <= pay_next;
    res_found <= res_found_next;
    res_drop  <= res_drop_next;
    res_word  <= res_word_next;
  end

  // sequencer: scan, shift and write back through the memory
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    sh_next        = sh;
    k_next         = k;
    prev_next      = prev;
    cmd_next       = cmd_q;
    stamp_next     = stamp_q;
    pay_next       = pay_q;
    res_found_next = res_found;
    res_drop_next  = res_drop;
    res_word_next  = res_word;
    rd_en          = 1'b0;
    rd_addr        = idx;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = {pay_q, stamp_q};

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_next       = req.cmd;
          stamp_next     = req.stamp;
          pay_next       = PAYLOAD_BITS'(req.payload);
          res_found_next = 1'b0;
          res_drop_next  = 1'b0;
          idx_next       = '0;
          case (req.cmd)
            CMD_INSERT: begin
              if (count == '0) begin
                // empty table: first entry goes straight in
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {PAYLOAD_BITS'(req.payload), req.stamp};
                count_next = CW'(1);
                state_next = ST_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_SCAN;
              end
            end
            CMD_LOOKUP: begin
              if (count == '0) begin
                state_next = ST_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_SCAN;
              end
            end
            CMD_READ: begin
              if (CMPW'(req.position) < CMPW'(count)) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(req.position);
                state_next = ST_READ;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cur_t >= stamp_q) begin
          // first entry not earlier than the request time
          if (cmd_q == CMD_INSERT) begin
            if (cur_t == stamp_q) begin
              wr_en      = 1'b1;
              wr_addr    = idx;
              state_next = ST_DONE;
            end else if (full) begin
              res_drop_next = 1'b1;
              state_next    = ST_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = last_addr;
              sh_next    = last_addr;
              k_next     = idx;
              state_next = ST_SHIFT;
            end
          end else begin
            res_found_next = 1'b1;
            res_word_next  = pick_prev ? prev : rd_data;
            state_next     = ST_DONE;
          end
        end else if (at_last) begin
          // request time is past every stored entry
          if (cmd_q == CMD_INSERT) begin
            if (full) begin
              res_drop_next = 1'b1;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = AW'(count);
              count_next = count + CW'(1);
            end
          end else begin
            res_found_next = 1'b1;
            res_word_next  = rd_data;
          end
          state_next = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx + AW'(1);
          idx_next  = idx + AW'(1);
          prev_next = rd_data;
        end
      end

      ST_SHIFT: begin
        // move one entry up, walking down toward the insert point
        wr_en   = 1'b1;
        wr_addr = sh + AW'(1);
        wr_data = rd_data;
        if (sh == k) begin
          state_next = ST_PLACE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = sh - AW'(1);
          sh_next = sh - AW'(1);
        end
      end

      ST_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = k;
        count_next = count + CW'(1);
        state_next = ST_DONE;
      end

      ST_READ: begin
        res_found_next = 1'b1;
        res_word_next  = rd_data;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TSET_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `TSET_ASSERT_NOW(a_count_step, count != $past(count), count == $past(count) + CW'(1), "entry count moved by other than one")
  `TSET_ASSERT_NOW(a_drop_full, state == ST_DONE && res_drop, full, "insert dropped while table not full")
  `TSET_ASSERT_NOW(a_write_insert, wr_en && state != ST_IDLE, cmd_q == CMD_INSERT, "memory written outside an insert")
  `TSET_ASSERT_NEXT(a_done_exit, state == ST_DONE && res_ready, state == ST_IDLE, "result handed over but sequencer stuck")

endmodule

// ===== design/time_sorted_event_table.sv =====
// insert and nearest lookup scan the table one entry per cycle through the memory read port,
//   from entry 0 up to the first entry not earlier than the request time, or the last entry
// an insert that lands inside the table shifts the later entries up one place, then writes the new one
// one request is in work at a time, the result register frees it
// rst (synchronous) empties the table; stored entries are not cleared and need no clearing pass
`timescale 1ns / 1ps

module time_sorted_event_table
  import tset_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // stamp[47:0], payload_in[79:48], position[83:80]
  input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // stamp_out[47:0], payload_out[79:48], fill[84:80]
  output logic [OUT_USER_W-1:0] m_tuser    // found[0], dropped[1]
);

  localparam int AW = $clog2(DEPTH);
  localparam int W  = STAMP_W + PAYLOAD_BITS;

  req_t          req;
  res_t          res;
  res_t          res_q;
  logic          res_valid;
  logic          slot_free;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [W-1:0]  rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;

  // unpack the incoming request
  always_comb begin
    req.cmd      = cmd_t'(s_tuser);
    req.stamp    = s_tdata[STAMP_W-1:0];
    req.payload  = s_tdata[STAMP_W+PAYLOAD_W-1:STAMP_W];
    req.position = s_tdata[STAMP_W+PAYLOAD_W+POS_W-1:STAMP_W+PAYLOAD_W];
  end

  assign slot_free = !m_tvalid || m_tready;

  tset_seq #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (slot_free),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  tset_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register holds one result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_tvalid <= res_valid;
    end
    if (slot_free && res_valid) begin
      res_q <= res;
    end
  end

  // pack the result
  assign m_tdata = {{(OUT_DATA_W - STAMP_W - PAYLOAD_W - FILL_W){1'b0}},
                    res_q.fill, res_q.payload, res_q.stamp};
  assign m_tuser = {res_q.dropped, res_q.found};

endmodule
